>>> hw/rtl/bafp_pkg.sv
// ----------------------------------------------------------------------------
// bafp_pkg
// Shared widths, angle constants and the arctangent table for the bond
// angle pipeline.
// ----------------------------------------------------------------------------
package bafp_pkg;

    // unit vector fraction bits (Q30)
    localparam int UNIT_BITS    = 30;
    // vectoring iterations
    localparam int CORDIC_STEPS = 26;
    // X (cosine side) width after the dot product
    localparam int X_W          = 34;
    // Y (sine side) width out of the square root
    localparam int Y_W          = 32;
    // CORDIC x/y working width
    localparam int XY_W         = 40;
    // angle accumulator width, degrees Q24
    localparam int Z_W          = 34;
    // result angle width, degrees Q16
    localparam int ANG_W        = 24;

    localparam logic signed [Z_W-1:0] DEG90_Q24  = 34'sd1509949440;
    localparam logic [ANG_W-1:0]      DEG180_Q16 = 24'd11796480;

    // atan(2^-i) in degrees, Q24, rounded
    function automatic logic signed [Z_W-1:0] atan_q24(input logic [4:0] idx);
        logic signed [Z_W-1:0] v;
        unique case (idx)
            5'd0:    v = 34'sd754974720;
            5'd1:    v = 34'sd445687602;
            5'd2:    v = 34'sd235489088;
            5'd3:    v = 34'sd119537938;
            5'd4:    v = 34'sd60000934;
            5'd5:    v = 34'sd30029717;
            5'd6:    v = 34'sd15018523;
            5'd7:    v = 34'sd7509720;
            5'd8:    v = 34'sd3754917;
            5'd9:    v = 34'sd1877466;
            5'd10:   v = 34'sd938734;
            5'd11:   v = 34'sd469367;
            5'd12:   v = 34'sd234684;
            5'd13:   v = 34'sd117342;
            5'd14:   v = 34'sd58671;
            5'd15:   v = 34'sd29335;
            5'd16:   v = 34'sd14668;
            5'd17:   v = 34'sd7334;
            5'd18:   v = 34'sd3667;
            5'd19:   v = 34'sd1833;
            5'd20:   v = 34'sd917;
            5'd21:   v = 34'sd458;
            5'd22:   v = 34'sd229;
            5'd23:   v = 34'sd115;
            5'd24:   v = 34'sd57;
            5'd25:   v = 34'sd29;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

>>> hw/rtl/bafp_isqrt.sv
// ----------------------------------------------------------------------------
// bafp_isqrt
// Pipelined integer square root, floor(sqrt(n)), one result bit per stage.
// Several lanes share one valid and one sideband word.
// ----------------------------------------------------------------------------
module bafp_isqrt #(
    parameter int RAD_W  = 64,
    parameter int LANES  = 1,
    parameter int SIDE_W = 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_vld,
    input  logic [RAD_W-1:0]     i_rad [LANES],
    input  logic [SIDE_W-1:0]    i_side,
    output logic                 o_vld,
    output logic [RAD_W/2-1:0]   o_root [LANES],
    output logic [SIDE_W-1:0]    o_side
);
    localparam int STEPS = RAD_W / 2;

    logic              r_vld  [STEPS];
    logic [RAD_W-1:0]  r_rem  [STEPS][LANES];
    logic [RAD_W-1:0]  r_root [STEPS][LANES];
    logic [SIDE_W-1:0] r_side [STEPS];

    for (genvar gs = 0; gs < STEPS; gs++) begin : g_st
        localparam logic [RAD_W-1:0] BIT = RAD_W'(1) << (RAD_W - 2 - 2 * gs);

        logic              v_in;
        logic [SIDE_W-1:0] s_in;
        logic [RAD_W-1:0]  rem_in  [LANES];
        logic [RAD_W-1:0]  root_in [LANES];
        logic [RAD_W-1:0]  trial   [LANES];

        // stage source: ports for the first stage, previous stage otherwise
        if (gs == 0) begin : g_src
            assign v_in    = i_vld;
            assign s_in    = i_side;
            assign rem_in  = i_rad;
            assign root_in = '{default: '0};
        end else begin : g_src
            assign v_in    = r_vld[gs-1];
            assign s_in    = r_side[gs-1];
            assign rem_in  = r_rem[gs-1];
            assign root_in = r_root[gs-1];
        end

        always_comb begin
            for (int l = 0; l < LANES; l++) begin
                trial[l] = root_in[l] + BIT;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[gs] <= 1'b0;
            end else if (i_en) begin
                r_vld[gs] <= v_in;
            end
        end

        // one restoring step per lane
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                for (int l = 0; l < LANES; l++) begin
                    if (rem_in[l] >= trial[l]) begin
                        r_rem[gs][l]  <= rem_in[l] - trial[l];
                        r_root[gs][l] <= (root_in[l] >> 1) + BIT;
                    end else begin
                        r_rem[gs][l]  <= rem_in[l];
                        r_root[gs][l] <= root_in[l] >> 1;
                    end
                end
                r_side[gs] <= s_in;
            end
        end
    end

    assign o_vld  = r_vld[STEPS-1];
    assign o_side = r_side[STEPS-1];

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            o_root[l] = r_root[STEPS-1][l][RAD_W/2-1:0];
        end
    end

endmodule

>>> hw/rtl/bafp_div.sv
// ----------------------------------------------------------------------------
// bafp_div
// Pipelined restoring divider: q = floor((num << SHIFT) / den), one
// quotient bit per stage. Assumes the quotient fits in Q_W bits.
// ----------------------------------------------------------------------------
module bafp_div #(
    parameter int NUM_W  = 30,
    parameter int DEN_W  = 31,
    parameter int SHIFT  = 30,
    parameter int Q_W    = 31,
    parameter int LANES  = 1,
    parameter int SIDE_W = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_vld,
    input  logic [NUM_W-1:0]  i_num [LANES],
    input  logic [DEN_W-1:0]  i_den [LANES],
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_vld,
    output logic [Q_W-1:0]    o_q [LANES],
    output logic [SIDE_W-1:0] o_side
);
    localparam int RW   = DEN_W + 1;
    localparam int DV_W = NUM_W + SHIFT;

    logic              r_vld  [Q_W];
    logic [RW-1:0]     r_rem  [Q_W][LANES];
    logic [NUM_W-1:0]  r_num  [Q_W][LANES];
    logic [DEN_W-1:0]  r_den  [Q_W][LANES];
    logic [Q_W-1:0]    r_q    [Q_W][LANES];
    logic [SIDE_W-1:0] r_side [Q_W];

    for (genvar gs = 0; gs < Q_W; gs++) begin : g_st
        localparam int BI = Q_W - 1 - gs;

        logic              v_in;
        logic [SIDE_W-1:0] s_in;
        logic [RW-1:0]     rem_in [LANES];
        logic [NUM_W-1:0]  num_in [LANES];
        logic [DEN_W-1:0]  den_in [LANES];
        logic [Q_W-1:0]    q_in   [LANES];
        logic [RW-1:0]     sh     [LANES];
        logic              ge     [LANES];

        if (gs == 0) begin : g_src
            assign v_in = i_vld;
            assign s_in = i_side;
            always_comb begin
                for (int l = 0; l < LANES; l++) begin
                    num_in[l] = i_num[l];
                    den_in[l] = i_den[l];
                    q_in[l]   = '0;
                    // dividend bits above the quotient seed the remainder
                    rem_in[l] = RW'({i_num[l], {SHIFT{1'b0}}} >> Q_W);
                end
            end
        end else begin : g_src
            assign v_in   = r_vld[gs-1];
            assign s_in   = r_side[gs-1];
            assign rem_in = r_rem[gs-1];
            assign num_in = r_num[gs-1];
            assign den_in = r_den[gs-1];
            assign q_in   = r_q[gs-1];
        end

        // bring down next dividend bit, trial subtract
        always_comb begin
            for (int l = 0; l < LANES; l++) begin
                logic [DV_W-1:0] dv;
                dv    = {num_in[l], {SHIFT{1'b0}}};
                sh[l] = {rem_in[l][RW-2:0], dv[BI]};
                ge[l] = sh[l] >= {1'b0, den_in[l]};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[gs] <= 1'b0;
            end else if (i_en) begin
                r_vld[gs] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                for (int l = 0; l < LANES; l++) begin
                    r_rem[gs][l] <= ge[l] ? (sh[l] - {1'b0, den_in[l]}) : sh[l];
                    r_q[gs][l]   <= {q_in[l][Q_W-2:0], ge[l]};
                    r_num[gs][l] <= num_in[l];
                    r_den[gs][l] <= den_in[l];
                end
                r_side[gs] <= s_in;
            end
        end
    end

    assign o_vld  = r_vld[Q_W-1];
    assign o_side = r_side[Q_W-1];
    assign o_q    = r_q[Q_W-1];

endmodule

>>> hw/rtl/bafp_cordic.sv
// ----------------------------------------------------------------------------
// bafp_cordic
// Vectoring CORDIC: angle of (x, y) in degrees Q24. One pre-rotation stage
// for the left half plane, then one iteration per stage.
// ----------------------------------------------------------------------------
module bafp_cordic #(
    parameter int SIDE_W = 1
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_vld,
    input  logic signed [bafp_pkg::X_W-1:0]   i_x,
    input  logic [bafp_pkg::Y_W-1:0]          i_y,
    input  logic [SIDE_W-1:0]                 i_side,
    output logic                              o_vld,
    output logic signed [bafp_pkg::Z_W-1:0]   o_z,
    output logic [SIDE_W-1:0]                 o_side
);
    import bafp_pkg::*;

    localparam logic signed [XY_W-1:0] XY_ZERO = '0;

    logic signed [XY_W-1:0] w_x_ext;
    logic signed [XY_W-1:0] w_y_ext;

    logic                   r_pv;
    logic signed [XY_W-1:0] r_px;
    logic signed [XY_W-1:0] r_py;
    logic signed [Z_W-1:0]  r_pz;
    logic [SIDE_W-1:0]      r_ps;

    logic                   r_v [CORDIC_STEPS];
    logic signed [XY_W-1:0] r_x [CORDIC_STEPS];
    logic signed [XY_W-1:0] r_y [CORDIC_STEPS];
    logic signed [Z_W-1:0]  r_z [CORDIC_STEPS];
    logic [SIDE_W-1:0]      r_s [CORDIC_STEPS];

    assign w_x_ext = XY_W'(i_x);
    assign w_y_ext = signed'({{(XY_W - Y_W){1'b0}}, i_y});

    // pre-rotation by 90 degrees when x is negative
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else if (i_en) begin
            r_pv <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (w_x_ext < 0) begin
                r_px <= w_y_ext;
                r_py <= -w_x_ext;
                r_pz <= DEG90_Q24;
            end else begin
                r_px <= w_x_ext;
                r_py <= w_y_ext;
                r_pz <= '0;
            end
            r_ps <= i_side;
        end
    end

    for (genvar gs = 0; gs < CORDIC_STEPS; gs++) begin : g_it
        localparam logic signed [XY_W-1:0] RND  = XY_W'((64'd1 << gs) - 64'd1);
        localparam logic signed [Z_W-1:0]  STEP = atan_q24(5'(gs));

        logic                   v_in;
        logic signed [XY_W-1:0] x_in;
        logic signed [XY_W-1:0] y_in;
        logic signed [Z_W-1:0]  z_in;
        logic [SIDE_W-1:0]      s_in;
        logic signed [XY_W-1:0] xb;
        logic signed [XY_W-1:0] yb;
        logic signed [XY_W-1:0] xs;
        logic signed [XY_W-1:0] ys;

        if (gs == 0) begin : g_src
            assign v_in = r_pv;
            assign x_in = r_px;
            assign y_in = r_py;
            assign z_in = r_pz;
            assign s_in = r_ps;
        end else begin : g_src
            assign v_in = r_v[gs-1];
            assign x_in = r_x[gs-1];
            assign y_in = r_y[gs-1];
            assign z_in = r_z[gs-1];
            assign s_in = r_s[gs-1];
        end

        // shifts truncate toward zero
        assign xb = x_in[XY_W-1] ? RND : XY_ZERO;
        assign yb = y_in[XY_W-1] ? RND : XY_ZERO;
        assign xs = (x_in + xb) >>> gs;
        assign ys = (y_in + yb) >>> gs;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[gs] <= 1'b0;
            end else if (i_en) begin
                r_v[gs] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!y_in[XY_W-1]) begin
                    r_x[gs] <= x_in + ys;
                    r_y[gs] <= y_in - xs;
                    r_z[gs] <= z_in + STEP;
                end else begin
                    r_x[gs] <= x_in - ys;
                    r_y[gs] <= y_in + xs;
                    r_z[gs] <= z_in - STEP;
                end
                r_s[gs] <= s_in;
            end
        end
    end

    assign o_vld  = r_v[CORDIC_STEPS-1];
    assign o_z    = r_z[CORDIC_STEPS-1];
    assign o_side = r_s[CORDIC_STEPS-1];

endmodule

>>> hw/rtl/bond_angle_from_three_points_core.sv
// ----------------------------------------------------------------------------
// bond_angle_from_three_points_core
// Angle at a vertex between two 3-D points, degrees Q8.16, via unit
// vectors, dot/cross products and a vectoring CORDIC.
//
//   channel   signals                              direction
//   input     i_valid / o_ready, nine coordinates  in
//   output    o_valid / i_ready, angle, degenerate out
//
// One transaction per cycle when the output side keeps taking results.
// The pipeline is 5 front stages, two 32-stage square roots, a
// 31-stage divider, 7 product stages, 27 CORDIC stages and the output reg.
// Synchronous active-low reset clears all valid bits; no clearing pass.
// A stalled output freezes the whole pipeline once a result lands in the
// skid register; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module bond_angle_from_three_points_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic signed [31:0]             i_first_x,
    input  logic signed [31:0]             i_first_y,
    input  logic signed [31:0]             i_first_z,
    input  logic signed [31:0]             i_vertex_x,
    input  logic signed [31:0]             i_vertex_y,
    input  logic signed [31:0]             i_vertex_z,
    input  logic signed [31:0]             i_third_x,
    input  logic signed [31:0]             i_third_y,
    input  logic signed [31:0]             i_third_z,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [bafp_pkg::ANG_W-1:0]     o_angle_deg,
    output logic                           o_degenerate
);
    import bafp_pkg::*;

    typedef struct packed {
        logic [2:0][29:0] na;
        logic [2:0][29:0] nb;
        logic [2:0]       sa;
        logic [2:0]       sb;
        logic             deg;
    } t_mag_side;

    typedef struct packed {
        logic [2:0] sa;
        logic [2:0] sb;
        logic       deg;
    } t_sgn_side;

    typedef struct packed {
        logic signed [X_W-1:0] x;
        logic                  deg;
    } t_y_side;

    // position of the leading one
    function automatic logic [5:0] msb33(input logic [32:0] v);
        logic [5:0] p;
        p = '0;
        for (int k = 0; k < 33; k++) begin
            if (v[k]) p = 6'(k);
        end
        return p;
    endfunction

    // bring the largest magnitude into [2^29, 2^30)
    function automatic logic [29:0] norm30(input logic [32:0] m, input logic [5:0] p);
        logic [29:0] r;
        if (p >= 6'd30) r = 30'(m >> (p - 6'd29));
        else            r = 30'(m << (6'd29 - p));
        return r;
    endfunction

    function automatic logic [32:0] max3(input logic [32:0] a, b, c);
        logic [32:0] m;
        m = (a > b) ? a : b;
        return (m > c) ? m : c;
    endfunction

    // signed divide by 2^30 toward zero
    function automatic logic signed [X_W-1:0] trunc30(input logic signed [63:0] v);
        logic signed [63:0] t;
        t = (v + (v[63] ? 64'sd1073741823 : 64'sd0)) >>> UNIT_BITS;
        return t[X_W-1:0];
    endfunction

    logic en;

    // front stages
    logic               r1_vld;
    logic signed [32:0] r1_a [3];
    logic signed [32:0] r1_b [3];

    logic               r2_vld;
    logic [32:0]        r2_ma [3];
    logic [32:0]        r2_mb [3];
    logic [2:0]         r2_sa;
    logic [2:0]         r2_sb;
    logic               r2_deg;

    logic               r3_vld;
    logic [29:0]        r3_na [3];
    logic [29:0]        r3_nb [3];
    logic [2:0]         r3_sa;
    logic [2:0]         r3_sb;
    logic               r3_deg;

    logic               r4_vld;
    logic [59:0]        r4_qa [3];
    logic [59:0]        r4_qb [3];
    t_mag_side          r4_side;

    logic               r5_vld;
    logic [63:0]        r5_rad [2];
    t_mag_side          r5_side;

    logic [32:0]        w_mxa;
    logic [32:0]        w_mxb;

    // square root of the squared lengths
    logic               s1_vld;
    logic [31:0]        s1_root [2];
    t_mag_side          s1_side;

    // unit components
    logic [29:0]        d_num [6];
    logic [30:0]        d_den [6];
    logic               d_vld;
    logic [30:0]        d_q [6];
    t_sgn_side          d_side_in;
    t_sgn_side          d_side;

    logic               r6_vld;
    logic signed [31:0] r6_ua [3];
    logic signed [31:0] r6_ub [3];
    logic               r6_deg;

    logic               r7_vld;
    logic signed [63:0] r7_dp [3];
    logic signed [63:0] r7_cp [6];
    logic               r7_deg;

    logic               r8_vld;
    logic signed [63:0] r8_dot;
    logic signed [63:0] r8_c [3];
    logic               r8_deg;

    logic                  r9_vld;
    logic signed [X_W-1:0] r9_x;
    logic signed [X_W-1:0] r9_c [3];
    logic                  r9_deg;

    logic                  r10_vld;
    logic signed [X_W-1:0] r10_x;
    logic [31:0]           r10_cm [3];
    logic                  r10_deg;

    logic                  r11_vld;
    logic signed [X_W-1:0] r11_x;
    logic [63:0]           r11_cq [3];
    logic                  r11_deg;

    logic                  r12_vld;
    logic [63:0]           r12_rad [1];
    t_y_side               r12_side;

    logic                  s2_vld;
    logic [31:0]           s2_root [1];
    t_y_side               s2_side;

    logic                  c_vld;
    logic signed [Z_W-1:0] c_z;
    logic                  c_deg;

    // output register and skid
    logic                  w_push;
    logic [ANG_W-1:0]      w_ang;
    logic signed [Z_W-1:0] w_zr;
    logic [ANG_W-1:0]      r_out_ang;
    logic                  r_out_deg;
    logic                  r_out_vld;
    logic [ANG_W-1:0]      r_skid_ang;
    logic                  r_skid_deg;
    logic                  r_skid_vld;

    // the pipeline advances whenever the skid is empty
    assign en      = ~r_skid_vld;
    assign o_ready = en;

    // valid chain of the front and product stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld  <= 1'b0;
            r2_vld  <= 1'b0;
            r3_vld  <= 1'b0;
            r4_vld  <= 1'b0;
            r5_vld  <= 1'b0;
            r6_vld  <= 1'b0;
            r7_vld  <= 1'b0;
            r8_vld  <= 1'b0;
            r9_vld  <= 1'b0;
            r10_vld <= 1'b0;
            r11_vld <= 1'b0;
            r12_vld <= 1'b0;
        end else if (en) begin
            r1_vld  <= i_valid;
            r2_vld  <= r1_vld;
            r3_vld  <= r2_vld;
            r4_vld  <= r3_vld;
            r5_vld  <= r4_vld;
            r6_vld  <= d_vld;
            r7_vld  <= r6_vld;
            r8_vld  <= r7_vld;
            r9_vld  <= r8_vld;
            r10_vld <= r9_vld;
            r11_vld <= r10_vld;
            r12_vld <= r11_vld;
        end
    end

    assign w_mxa   = max3(r2_ma[0], r2_ma[1], r2_ma[2]);
    assign w_mxb   = max3(r2_mb[0], r2_mb[1], r2_mb[2]);

    // stages 1..5: difference vectors, magnitudes, scaling, squares, sums
    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_a[0] <= 33'(i_first_x) - 33'(i_vertex_x);
            r1_a[1] <= 33'(i_first_y) - 33'(i_vertex_y);
            r1_a[2] <= 33'(i_first_z) - 33'(i_vertex_z);
            r1_b[0] <= 33'(i_third_x) - 33'(i_vertex_x);
            r1_b[1] <= 33'(i_third_y) - 33'(i_vertex_y);
            r1_b[2] <= 33'(i_third_z) - 33'(i_vertex_z);

            for (int i = 0; i < 3; i++) begin
                r2_ma[i] <= r1_a[i][32] ? 33'(-r1_a[i]) : 33'(r1_a[i]);
                r2_mb[i] <= r1_b[i][32] ? 33'(-r1_b[i]) : 33'(r1_b[i]);
                r2_sa[i] <= r1_a[i][32];
                r2_sb[i] <= r1_b[i][32];
            end
            r2_deg <= (r1_a[0] == 0 && r1_a[1] == 0 && r1_a[2] == 0) ||
                      (r1_b[0] == 0 && r1_b[1] == 0 && r1_b[2] == 0);

            for (int i = 0; i < 3; i++) begin
                r3_na[i] <= norm30(r2_ma[i], msb33(w_mxa));
                r3_nb[i] <= norm30(r2_mb[i], msb33(w_mxb));
            end
            r3_sa  <= r2_sa;
            r3_sb  <= r2_sb;
            r3_deg <= r2_deg;

            for (int i = 0; i < 3; i++) begin
                r4_qa[i]      <= r3_na[i] * r3_na[i];
                r4_qb[i]      <= r3_nb[i] * r3_nb[i];
                r4_side.na[i] <= r3_na[i];
                r4_side.nb[i] <= r3_nb[i];
            end
            r4_side.sa  <= r3_sa;
            r4_side.sb  <= r3_sb;
            r4_side.deg <= r3_deg;

            r5_rad[0] <= 64'(r4_qa[0]) + 64'(r4_qa[1]) + 64'(r4_qa[2]);
            r5_rad[1] <= 64'(r4_qb[0]) + 64'(r4_qb[1]) + 64'(r4_qb[2]);
            r5_side   <= r4_side;
        end
    end

    bafp_isqrt #(
        .RAD_W  (64),
        .LANES  (2),
        .SIDE_W ($bits(t_mag_side))
    ) u_len_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r5_vld),
        .i_rad   (r5_rad),
        .i_side  (r5_side),
        .o_vld   (s1_vld),
        .o_root  (s1_root),
        .o_side  (s1_side)
    );

    // lengths fit 31 bits: largest square sum is below 2^62
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            d_num[i]     = s1_side.na[i];
            d_num[i + 3] = s1_side.nb[i];
            d_den[i]     = s1_root[0][30:0];
            d_den[i + 3] = s1_root[1][30:0];
        end
        d_side_in.sa  = s1_side.sa;
        d_side_in.sb  = s1_side.sb;
        d_side_in.deg = s1_side.deg;
    end

    bafp_div #(
        .NUM_W  (30),
        .DEN_W  (31),
        .SHIFT  (UNIT_BITS),
        .Q_W    (31),
        .LANES  (6),
        .SIDE_W ($bits(t_sgn_side))
    ) u_unit_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (s1_vld),
        .i_num   (d_num),
        .i_den   (d_den),
        .i_side  (d_side_in),
        .o_vld   (d_vld),
        .o_q     (d_q),
        .o_side  (d_side)
    );

    // stages 6..12: signed units, products, sums, scaling, cross magnitudes, squares, sum
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r6_ua[i] <= d_side.sa[i] ? -signed'({1'b0, d_q[i]})
                                         :  signed'({1'b0, d_q[i]});
                r6_ub[i] <= d_side.sb[i] ? -signed'({1'b0, d_q[i + 3]})
                                         :  signed'({1'b0, d_q[i + 3]});
            end
            r6_deg <= d_side.deg;

            for (int i = 0; i < 3; i++) begin
                r7_dp[i] <= r6_ua[i] * r6_ub[i];
            end
            r7_cp[0] <= r6_ua[1] * r6_ub[2];
            r7_cp[1] <= r6_ua[2] * r6_ub[1];
            r7_cp[2] <= r6_ua[2] * r6_ub[0];
            r7_cp[3] <= r6_ua[0] * r6_ub[2];
            r7_cp[4] <= r6_ua[0] * r6_ub[1];
            r7_cp[5] <= r6_ua[1] * r6_ub[0];
            r7_deg   <= r6_deg;

            r8_dot <= r7_dp[0] + r7_dp[1] + r7_dp[2];
            for (int i = 0; i < 3; i++) begin
                r8_c[i] <= r7_cp[2 * i] - r7_cp[2 * i + 1];
            end
            r8_deg <= r7_deg;

            r9_x <= trunc30(r8_dot);
            for (int i = 0; i < 3; i++) begin
                r9_c[i] <= trunc30(r8_c[i]);
            end
            r9_deg <= r8_deg;

            r10_x <= r9_x;
            for (int i = 0; i < 3; i++) begin
                r10_cm[i] <= r9_c[i][X_W-1] ? 32'(-r9_c[i]) : 32'(r9_c[i]);
            end
            r10_deg <= r9_deg;

            r11_x <= r10_x;
            for (int i = 0; i < 3; i++) begin
                r11_cq[i] <= 64'(r10_cm[i]) * 64'(r10_cm[i]);
            end
            r11_deg <= r10_deg;

            r12_rad[0]   <= r11_cq[0] + r11_cq[1] + r11_cq[2];
            r12_side.x   <= r11_x;
            r12_side.deg <= r11_deg;
        end
    end

    bafp_isqrt #(
        .RAD_W  (64),
        .LANES  (1),
        .SIDE_W ($bits(t_y_side))
    ) u_sin_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r12_vld),
        .i_rad   (r12_rad),
        .i_side  (r12_side),
        .o_vld   (s2_vld),
        .o_root  (s2_root),
        .o_side  (s2_side)
    );

    bafp_cordic #(
        .SIDE_W (1)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (s2_vld),
        .i_x     (s2_side.x),
        .i_y     (s2_root[0]),
        .i_side  (s2_side.deg),
        .o_vld   (c_vld),
        .o_z     (c_z),
        .o_side  (c_deg)
    );

    // round Q24 to Q16 and clamp to [0, 180]; degenerate results give 0
    always_comb begin
        w_zr = c_z + 34'sd128;
        if (c_deg || c_z < 0) begin
            w_ang = '0;
        end else if (w_zr[Z_W-1:8] > 26'(DEG180_Q16)) begin
            w_ang = DEG180_Q16;
        end else begin
            w_ang = w_zr[ANG_W+7:8];
        end
    end

    assign w_push = c_vld & en;

    // output register with skid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (!r_out_vld || i_ready) begin
            if (r_skid_vld) begin
                r_out_vld  <= 1'b1;
                r_skid_vld <= 1'b0;
            end else begin
                r_out_vld  <= w_push;
            end
        end else if (w_push) begin
            r_skid_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_vld || i_ready) begin
            if (r_skid_vld) begin
                r_out_ang <= r_skid_ang;
                r_out_deg <= r_skid_deg;
            end else begin
                r_out_ang <= w_ang;
                r_out_deg <= c_deg;
            end
        end else if (w_push) begin
            r_skid_ang <= w_ang;
            r_skid_deg <= c_deg;
        end
    end

    assign o_valid      = r_out_vld;
    assign o_angle_deg  = r_out_ang;
    assign o_degenerate = r_out_deg;

endmodule
